// File: rtl/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// shared types and codes of the two-phase tile scheduler
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int CYCLE_W   = 16;          // width of a phase length register
    localparam int TIMER_W   = CYCLE_W + 1; // holds -1 up to the largest count
    localparam int TILE_IN_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int PHASE_W   = 3;
    localparam int MODE_W    = 2;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SCOMP  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SDRAIN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PCOMP  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PDRAIN = 3'd4;

    // array mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SDDMM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPMM  = 2'd2;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SDDMM_COMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SDDMM_DRAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPMM_COMP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPMM_DRAIN  = 2'd3;

    // compute timers start one below zero
    localparam logic [TIMER_W-1:0] TIMER_START = {TIMER_W{1'b1}};

    typedef struct packed {
        logic               array_on;
        logic [MODE_W-1:0]  op_mode;
        logic               clear_array;
        logic               clear_datapath;
        logic [PHASE_W-1:0] phase;
        logic               done_res;
    } t_result;

endpackage

// File: rtl/tps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_in_if
// input item channel: tick or workload load
// ----------------------------------------------------------------------------
interface tps_in_if
    import tps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic                 memory_ready;
    logic [TILE_IN_W-1:0] tile_count;

    modport source (output valid, output kind, output memory_ready,
                    output tile_count, input ready);
    modport sink   (input valid, input kind, input memory_ready,
                    input tile_count, output ready);
endinterface

// File: rtl/tps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_out_if
// result item channel: array controls and status
// ----------------------------------------------------------------------------
interface tps_out_if
    import tps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               array_on;
    logic [MODE_W-1:0]  op_mode;
    logic               clear_array;
    logic               clear_datapath;
    logic [PHASE_W-1:0] phase;
    logic               done_res;

    modport source (output valid, output array_on, output op_mode,
                    output clear_array, output clear_datapath, output phase,
                    output done_res, input ready);
    modport sink   (input valid, input array_on, input op_mode,
                    input clear_array, input clear_datapath, input phase,
                    input done_res, output ready);
endinterface

// File: rtl/tps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_core
// phase sequencer state, length registers and next-state logic
// ----------------------------------------------------------------------------
module tps_core
    import tps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_fire,
    input  logic                 i_kind,
    input  logic                 i_memory_ready,
    input  logic [TILE_IN_W-1:0] i_tile_count,
    output t_result              o_result
);

    logic [CYCLE_W-1:0]     r_sc_cycles, r_sd_cycles, r_pc_cycles, r_pd_cycles;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [TIMER_W-1:0]     r_timer, n_timer;
    logic [COUNT_WIDTH-1:0] r_tiles, n_tiles;
    logic                   r_enable, n_enable;
    logic [MODE_W-1:0]      r_mode, n_mode;

    logic [TIMER_W-1:0]     timer_inc;
    logic [COUNT_WIDTH-1:0] tiles_dec;
    logic                   clr_a, clr_d, start;

    // timer + 1 against the length: phase ends when it reaches the count
    function automatic logic over(input logic [TIMER_W-1:0] t,
                                  input logic [CYCLE_W-1:0] n);
        return t >= {1'b0, n};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_cycles <= '0;
            r_sd_cycles <= '0;
            r_pc_cycles <= '0;
            r_pd_cycles <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SDDMM_COMP:  r_sc_cycles <= i_cfg_data;
                CFG_SDDMM_DRAIN: r_sd_cycles <= i_cfg_data;
                CFG_SPMM_COMP:   r_pc_cycles <= i_cfg_data;
                CFG_SPMM_DRAIN:  r_pd_cycles <= i_cfg_data;
            endcase
        end
    end

    assign timer_inc = r_timer + TIMER_W'(1);
    assign tiles_dec = (r_tiles != '0) ? r_tiles - COUNT_WIDTH'(1) : '0;

    always_comb begin
        n_phase  = r_phase;
        n_timer  = timer_inc;
        n_tiles  = r_tiles;
        n_enable = 1'b1;
        n_mode   = r_mode;
        clr_a    = 1'b0;
        clr_d    = 1'b0;
        start    = 1'b0;
        if (i_kind == KIND_LOAD) begin
            n_tiles  = COUNT_WIDTH'(i_tile_count);
            n_phase  = PH_IDLE;
            n_timer  = '0;
            n_enable = 1'b0;
            n_mode   = MODE_IDLE;
        end else begin
            unique case (r_phase)
                PH_SCOMP: begin
                    n_mode = MODE_SDDMM;
                    if (over(timer_inc, r_sc_cycles)) begin
                        n_phase = PH_SDRAIN;
                        n_timer = '0;
                    end
                end
                PH_SDRAIN: begin
                    n_mode = MODE_SDDMM;
                    if (over(timer_inc, r_sd_cycles)) begin
                        n_phase = PH_PCOMP;
                        n_timer = TIMER_START;
                        n_mode  = MODE_SPMM;
                        clr_d   = 1'b1;
                    end
                end
                PH_PCOMP: begin
                    n_mode = MODE_SPMM;
                    if (over(timer_inc, r_pc_cycles)) begin
                        n_phase = PH_PDRAIN;
                        n_timer = '0;
                    end
                end
                PH_PDRAIN: begin
                    n_mode = MODE_SPMM;
                    if (over(timer_inc, r_pd_cycles)) begin
                        n_tiles = tiles_dec;
                        n_timer = '0;
                        if (tiles_dec != '0 && i_memory_ready) begin
                            start = 1'b1;
                        end else begin
                            n_phase  = PH_IDLE;
                            n_enable = 1'b0;
                            n_mode   = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase  = PH_IDLE;
                    n_enable = 1'b0;
                    n_mode   = MODE_IDLE;
                    n_timer  = '0;
                    start    = (r_tiles != '0) && i_memory_ready;
                end
            endcase
            if (start) begin
                n_phase  = PH_SCOMP;
                n_timer  = TIMER_START;
                n_enable = 1'b1;
                n_mode   = MODE_SDDMM;
                clr_a    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_tiles  <= '0;
            r_enable <= 1'b0;
            r_mode   <= MODE_IDLE;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_tiles  <= n_tiles;
            r_enable <= n_enable;
            r_mode   <= n_mode;
        end
    end

    always_comb begin
        o_result.array_on       = n_enable;
        o_result.op_mode        = n_mode;
        o_result.clear_array    = clr_a;
        o_result.clear_datapath = clr_d;
        o_result.phase          = n_phase;
        o_result.done_res       = (n_tiles == '0) && (n_phase == PH_IDLE);
    end

    // idle means the array is off
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (!r_enable && r_mode == MODE_IDLE))
        else $error("array enabled while idle");

    // first half of a tile runs in sddmm mode
    a_sddmm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SCOMP || r_phase == PH_SDRAIN) |-> (r_mode == MODE_SDDMM))
        else $error("wrong mode in sddmm phase");

    // a load returns to idle with the new tile count
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind == KIND_LOAD) |=>
        (r_phase == PH_IDLE && r_tiles == COUNT_WIDTH'($past(i_tile_count))))
        else $error("load did not reset the sequencer");

endmodule

// File: rtl/tps_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_out_buf
// two-entry result buffer between the sequencer and the result channel
// ----------------------------------------------------------------------------
module tps_out_buf
    import tps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = i_pop && (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // never written past full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("result buffer overflow");

endmodule

// File: rtl/two_phase_tile_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_tile_scheduler_unit
// per-tick sequencer stepping tiles through sddmm and spmm phases
// ----------------------------------------------------------------------------
// a result item is written into the result buffer as its input item is taken
// throughput: one item per cycle while the buffer has a free slot; the sequencer state updates in one pass
// a two-entry result buffer keeps input flowing while a result waits
// reset (synchronous, active low) clears phase, timer, tile count, controls
// and the four phase length registers
module two_phase_tile_scheduler_unit
    import tps_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    tps_in_if.sink               i_item,
    tps_out_if.source            o_result
);

    // sequencer output for the item in hand
    t_result next_res;
    t_result buf_res;
    logic    fire;
    logic    space;

    // an item is taken whenever the buffer has a free slot
    assign i_item.ready = space;
    assign fire         = i_item.valid && space;

    // state and length registers, next-state logic
    tps_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_fire         (fire),
        .i_kind         (i_item.kind),
        .i_memory_ready (i_item.memory_ready),
        .i_tile_count   (i_item.tile_count),
        .o_result       (next_res)
    );

    // result register plus skid slot
    tps_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (next_res),
        .o_space (space),
        .o_valid (o_result.valid),
        .i_pop   (o_result.ready),
        .o_data  (buf_res)
    );

    // unpack onto the result channel
    assign o_result.array_on       = buf_res.array_on;
    assign o_result.op_mode        = buf_res.op_mode;
    assign o_result.clear_array    = buf_res.clear_array;
    assign o_result.clear_datapath = buf_res.clear_datapath;
    assign o_result.phase          = buf_res.phase;
    assign o_result.done_res       = buf_res.done_res;

endmodule

// File: tb/two_phase_tile_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_tile_scheduler_unit_tb
// self-checking bench: a clocked driver feeds tick and load items from a
// backlog, a sequencer model predicts every control item, and a clocked
// monitor compares them while both sides idle at random and the receiver
// holds off once for a long stretch; phase lengths change between runs
// ----------------------------------------------------------------------------
module two_phase_tile_scheduler_unit_tb;
    import tps_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int HOLD_CYCLES    = 90;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000; // quiet cycles before giving up
    localparam int SETTINGS_RUNS  = 8;

    typedef struct packed {
        logic                 kind;
        logic                 memory_ready;
        logic [TILE_IN_W-1:0] tile_count;
    } t_sched_cmd;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    tps_in_if  item_if ();
    tps_out_if res_if ();

    two_phase_tile_scheduler_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    // clock, 12 ns period
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // items waiting to be offered and control items still to arrive
    t_sched_cmd cmd_backlog[$];
    t_result    control_queue[$];

    // sequencer model state, a private copy of the block's
    logic [PHASE_W-1:0]   seq_phase;
    int                   seq_timer;   // -1 up to the longest phase
    logic [TILE_IN_W-1:0] seq_tiles;
    logic                 seq_enable;
    logic [MODE_W-1:0]    seq_mode;
    int                   phase_len[4]; // indexed by register code

    // idling control, set between runs by the stimulus process
    bit source_idle_on;
    bit sink_idle_on;
    int hold_requests;

    int errors;
    int n_ticks;
    int n_loads;
    int n_tiles_started;
    int n_checked;
    int n_settings;

    // a phase of length n has had its last cycle once the timer reaches n-1
    function automatic bit timer_at_end(int len);
        return seq_timer >= len - 1;
    endfunction

    // advance the sequencer by one item and return the controls it shows after
    function automatic t_result advance_sequencer(logic kind, logic mem_rdy,
                                                  logic [TILE_IN_W-1:0] count);
        t_result              r;
        logic [PHASE_W-1:0]   nph;
        int                   ntim;
        logic [TILE_IN_W-1:0] ntl;
        logic                 nen;
        logic [MODE_W-1:0]    nmode;
        bit                   start;
        r = '0;
        if (kind == KIND_LOAD) begin
            // a load drops whatever was running and clears the controls
            seq_tiles  = count;
            seq_phase  = PH_IDLE;
            seq_timer  = 0;
            seq_enable = 1'b0;
            seq_mode   = MODE_IDLE;
        end else begin
            nph   = seq_phase;
            ntim  = seq_timer + 1;
            ntl   = seq_tiles;
            nen   = 1'b1;
            nmode = seq_mode;
            start = 1'b0;
            case (seq_phase)
                PH_SCOMP: begin
                    nmode = MODE_SDDMM;
                    if (timer_at_end(phase_len[CFG_SDDMM_COMP])) begin
                        nph  = PH_SDRAIN;
                        ntim = 0;
                    end
                end
                PH_SDRAIN: begin
                    nmode = MODE_SDDMM;
                    if (timer_at_end(phase_len[CFG_SDDMM_DRAIN])) begin
                        nph  = PH_PCOMP;
                        ntim = -1;
                        nmode = MODE_SPMM;
                        r.clear_datapath = 1'b1;
                    end
                end
                PH_PCOMP: begin
                    nmode = MODE_SPMM;
                    if (timer_at_end(phase_len[CFG_SPMM_COMP])) begin
                        nph  = PH_PDRAIN;
                        ntim = 0;
                    end
                end
                PH_PDRAIN: begin
                    nmode = MODE_SPMM;
                    if (timer_at_end(phase_len[CFG_SPMM_DRAIN])) begin
                        // tile finished: count down, saturating at zero
                        if (ntl != '0) ntl = ntl - 1'b1;
                        ntim = 0;
                        if (ntl != '0 && mem_rdy) begin
                            start = 1'b1;
                        end else begin
                            nph   = PH_IDLE;
                            nen   = 1'b0;
                            nmode = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    nph   = PH_IDLE;
                    nen   = 1'b0;
                    nmode = MODE_IDLE;
                    ntim  = 0;
                    if (ntl != '0 && mem_rdy) start = 1'b1;
                end
            endcase
            if (start) begin
                nph   = PH_SCOMP;
                ntim  = -1;
                nen   = 1'b1;
                nmode = MODE_SDDMM;
                r.clear_array = 1'b1;
            end
            seq_phase  = nph;
            seq_timer  = ntim;
            seq_tiles  = ntl;
            seq_enable = nen;
            seq_mode   = nmode;
        end
        r.array_on = seq_enable;
        r.op_mode  = seq_mode;
        r.phase    = seq_phase;
        r.done_res = (seq_tiles == '0) && (seq_phase == PH_IDLE);
        return r;
    endfunction

    // per-item wait of either side, often none
    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    task automatic check_field(string field_name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", field_name, exp_val, act_val);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers backlog items, predicts each one as it is taken
    // ------------------------------------------------------------------
    int gap_left;

    always @(posedge i_clk) begin : item_driver
        t_sched_cmd c;
        t_result    r;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            gap_left      <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                r = advance_sequencer(item_if.kind, item_if.memory_ready,
                                      item_if.tile_count);
                control_queue.push_back(r);
                if (item_if.kind == KIND_LOAD) n_loads++;
                else n_ticks++;
                if (r.clear_array) n_tiles_started++;
            end
            // slot is free once the current item has gone or none is offered
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    item_if.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (cmd_backlog.size() != 0) begin
                    c = cmd_backlog.pop_front();
                    item_if.valid        <= 1'b1;
                    item_if.kind         <= c.kind;
                    item_if.memory_ready <= c.memory_ready;
                    item_if.tile_count   <= c.tile_count;
                    gap_left             <= source_idle_on ? draw_gap() : 0;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each control item against the oldest prediction
    // ------------------------------------------------------------------
    int stall_left;
    int hold_left;
    int holds_served;

    always @(posedge i_clk) begin : control_monitor
        t_result exp_r;
        int      stall;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            holds_served <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (control_queue.size() == 0) begin
                    $error("control item arrived with none predicted");
                    errors++;
                end else begin
                    exp_r = control_queue.pop_front();
                    n_checked++;
                    check_field("array_on", exp_r.array_on, res_if.array_on);
                    check_field("op_mode", exp_r.op_mode, res_if.op_mode);
                    check_field("clear_array", exp_r.clear_array, res_if.clear_array);
                    check_field("clear_datapath", exp_r.clear_datapath,
                                res_if.clear_datapath);
                    check_field("phase", exp_r.phase, res_if.phase);
                    check_field("done_res", exp_r.done_res, res_if.done_res);
                end
            end
            // ready: long hold-off first, then per-item stalls
            if (hold_requests != holds_served) begin
                holds_served <= hold_requests;
                hold_left    <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_if.ready <= (hold_left == 1);
            end else if (res_if.valid && res_if.ready) begin
                stall = sink_idle_on ? draw_gap() : 0;
                stall_left   <= stall;
                res_if.ready <= (stall == 0);
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                res_if.ready <= (stall_left == 1);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready)
                     || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_sched_cmd tick_cmd(logic rdy);
        t_sched_cmd c;
        c.kind         = KIND_TICK;
        c.memory_ready = rdy;
        c.tile_count   = TILE_IN_W'($urandom_range(0, 65535)); // ignored on ticks
        return c;
    endfunction

    function automatic t_sched_cmd load_cmd(logic [TILE_IN_W-1:0] count);
        t_sched_cmd c;
        c.kind         = KIND_LOAD;
        c.memory_ready = 1'($urandom_range(0, 1)); // ignored on loads
        c.tile_count   = count;
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_len[idx] = val;
    endtask

    task automatic program_lengths(int sc, int sd, int pc, int pd);
        write_reg(CFG_SDDMM_COMP, CFG_DAT_W'(sc));
        write_reg(CFG_SDDMM_DRAIN, CFG_DAT_W'(sd));
        write_reg(CFG_SPMM_COMP, CFG_DAT_W'(pc));
        write_reg(CFG_SPMM_DRAIN, CFG_DAT_W'(pd));
        n_settings++;
    endtask

    // loads followed by runs of ticks; runs of random length cut tiles short
    task automatic queue_workloads(int target);
        int n;
        int run;
        int pick;
        n = 0;
        while (n < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) cmd_backlog.push_back(load_cmd('0));
            else if (pick == 1)
                cmd_backlog.push_back(load_cmd(TILE_IN_W'($urandom_range(0, 65535))));
            else
                cmd_backlog.push_back(load_cmd(TILE_IN_W'($urandom_range(1, 4))));
            n++;
            run = $urandom_range(8, 40);
            repeat (run) begin
                cmd_backlog.push_back(tick_cmd($urandom_range(0, 4) != 0));
                n++;
            end
        end
    endtask

    // wait until every item is taken and every control item checked
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || item_if.valid || control_queue.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int run_idx;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        item_if.valid        = 1'b0;
        item_if.kind         = KIND_TICK;
        item_if.memory_ready = 1'b0;
        item_if.tile_count   = '0;
        res_if.ready         = 1'b0;
        seq_phase  = PH_IDLE;
        seq_timer  = 0;
        seq_tiles  = '0;
        seq_enable = 1'b0;
        seq_mode   = MODE_IDLE;
        phase_len  = '{0, 0, 0, 0};
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        hold_requests  = 0;
        errors = 0;
        n_ticks = 0;
        n_loads = 0;
        n_tiles_started = 0;
        n_checked = 0;
        n_settings = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, all lengths at their reset value of zero
        @(negedge i_clk);
        cmd_backlog.push_back(load_cmd('0));          // empty workload
        cmd_backlog.push_back(tick_cmd(1'b1));        // nothing to start
        cmd_backlog.push_back(load_cmd('1));          // largest tile count
        cmd_backlog.push_back(tick_cmd(1'b0));        // memory not ready
        cmd_backlog.push_back(tick_cmd(1'b1));        // tile starts
        repeat (3) cmd_backlog.push_back(tick_cmd(1'b1)); // one cycle per phase
        cmd_backlog.push_back(tick_cmd(1'b1));        // back-to-back tile
        repeat (3) cmd_backlog.push_back(tick_cmd(1'b0));
        cmd_backlog.push_back(tick_cmd(1'b0));        // tile ends, memory not ready
        cmd_backlog.push_back(tick_cmd(1'b1));        // restart from idle
        cmd_backlog.push_back(tick_cmd(1'b1));
        cmd_backlog.push_back(load_cmd(TILE_IN_W'(1))); // load in the middle of a tile
        cmd_backlog.push_back(tick_cmd(1'b1));
        repeat (3) cmd_backlog.push_back(tick_cmd(1'b1));
        cmd_backlog.push_back(tick_cmd(1'b1));        // last tile done
        cmd_backlog.push_back(tick_cmd(1'b1));        // stays done
        wait_drained();

        for (run_idx = 0; run_idx < SETTINGS_RUNS; run_idx++) begin
            source_idle_on = 1'b1;
            sink_idle_on   = 1'b1;
            case (run_idx)
                0: program_lengths(1, 2, 1, 2);
                1: begin
                    // no idling on either side
                    source_idle_on = 1'b0;
                    sink_idle_on   = 1'b0;
                    program_lengths($urandom_range(0, 4), $urandom_range(0, 4),
                                    $urandom_range(0, 4), $urandom_range(0, 4));
                end
                2: begin
                    // sender keeps offering while the receiver holds off
                    source_idle_on = 1'b0;
                    program_lengths($urandom_range(0, 8), $urandom_range(0, 8),
                                    $urandom_range(0, 8), $urandom_range(0, 8));
                end
                4: program_lengths(65535, 65535, 65535, 65535);
                5: program_lengths($urandom_range(0, 5), $urandom_range(0, 5),
                                   $urandom_range(0, 5), $urandom_range(0, 5));
                6: program_lengths(0, 0, 0, 0);
                default: program_lengths($urandom_range(0, 10), $urandom_range(0, 10),
                                         $urandom_range(0, 10), $urandom_range(0, 10));
            endcase
            @(negedge i_clk);
            if (run_idx == 4) begin
                // longest lengths: a tile starts and sits in sddmm compute
                cmd_backlog.push_back(load_cmd(TILE_IN_W'(2)));
                repeat (24) cmd_backlog.push_back(tick_cmd(1'b1));
            end else begin
                // after the longest lengths, short ones take effect mid-phase
                if (run_idx == 5) repeat (6) cmd_backlog.push_back(tick_cmd(1'b1));
                queue_workloads(125);
            end
            if (run_idx == 2) begin
                repeat (5) @(negedge i_clk);
                hold_requests++;
            end
            wait_drained();
        end

        // let any stray control item show up
        repeat (4) @(negedge i_clk);
        if (control_queue.size() != 0) begin
            $error("%0d control items never arrived", control_queue.size());
            errors++;
        end

        $display("covered %0d ticks and %0d loads, %0d tiles started, %0d items checked",
                 n_ticks, n_loads, n_tiles_started, n_checked);
        $display("over %0d phase length settings, from all zero to all ones",
                 n_settings);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
